>>> rtl/event_timer_block_unit_defines.svh
// Assertion macros for the event timer block.
`ifndef EVENT_TIMER_BLOCK_UNIT_DEFINES_SVH
`define EVENT_TIMER_BLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ETB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ETB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/etb_pkg.sv
package etb_pkg;

   // item kinds
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_TICK_PERIOD = 2'd0;
   localparam logic [1:0] CSR_WIDE_CAP    = 2'd1;
   localparam logic [1:0] CSR_LEGACY_CAP  = 2'd2;
   localparam logic [1:0] CSR_PER_MASK    = 2'd3;

   localparam int TICK_PERIOD_W = 27;
   localparam int PMASK_W       = 3;
   localparam logic [TICK_PERIOD_W-1:0] TICK_PERIOD_RST = 27'd69841279;
   localparam logic [PMASK_W-1:0]       PMASK_RST       = 3'd1;

   // register window offsets
   localparam logic [8:0] OFS_CAPS   = 9'h000;
   localparam logic [8:0] OFS_CONFIG = 9'h010;
   localparam logic [8:0] OFS_STATUS = 9'h020;
   localparam logic [8:0] OFS_COUNT  = 9'h0F0;
   localparam int         TMR_SLOTS  = 8;

   localparam logic [7:0]  CAPS_REV    = 8'h01;
   localparam logic [15:0] CAPS_VENDOR = 16'h8086;

   // timer control bits
   localparam int CTRL_LEVEL    = 1;
   localparam int CTRL_ENABLE   = 2;
   localparam int CTRL_PERIODIC = 3;
   localparam int CTRL_PER_CAP  = 4;
   localparam int CTRL_WIDE_CAP = 5;
   localparam int CTRL_SETVAL   = 6;
   localparam int CTRL_MODE32   = 8;
   localparam logic [15:0] CTRL_WRITABLE = 16'h3F4E;
   localparam logic [15:0] CTRL_READABLE = 16'h3F0E;

   typedef struct packed {
      logic [TICK_PERIOD_W-1:0] tick_period;
      logic                     wide_cap;
      logic                     legacy_cap;
      logic [PMASK_W-1:0]       per_mask;
   } cfg_type;

   // one decoded operation, already qualified by the pipeline
   typedef struct packed {
      logic        tick;
      logic        write;
      logic [8:0]  base;
      logic [63:0] lane;
      logic [63:0] data;
   } op_type;

   typedef struct packed {
      logic        hit;
      logic        level_en;
      logic        pulse;
      logic        set_status;
      logic [63:0] rdata;
   } tmr_out_type;

endpackage

>>> rtl/etb_csr.sv
module etb_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output etb_pkg::cfg_type  cfg
);

   etb_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            etb_pkg::CSR_TICK_PERIOD:
               cfg_in.tick_period = csr_pwdata[etb_pkg::TICK_PERIOD_W-1:0];
            etb_pkg::CSR_WIDE_CAP:   cfg_in.wide_cap   = csr_pwdata[0];
            etb_pkg::CSR_LEGACY_CAP: cfg_in.legacy_cap = csr_pwdata[0];
            etb_pkg::CSR_PER_MASK:
               cfg_in.per_mask = csr_pwdata[etb_pkg::PMASK_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         etb_pkg::CSR_TICK_PERIOD: csr_prdata = 32'(cfg_ff.tick_period);
         etb_pkg::CSR_WIDE_CAP:    csr_prdata = 32'(cfg_ff.wide_cap);
         etb_pkg::CSR_LEGACY_CAP:  csr_prdata = 32'(cfg_ff.legacy_cap);
         etb_pkg::CSR_PER_MASK:    csr_prdata = 32'(cfg_ff.per_mask);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period <= etb_pkg::TICK_PERIOD_RST;
         cfg_ff.wide_cap    <= 1'b1;
         cfg_ff.legacy_cap  <= 1'b1;
         cfg_ff.per_mask    <= etb_pkg::PMASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/etb_timer.sv
module etb_timer #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  etb_pkg::op_type       op,
   input  logic [63:0]           count_next,
   input  etb_pkg::cfg_type      cfg,
   output etb_pkg::tmr_out_type  tout
);

   localparam logic       IN_WIN = (IDX < etb_pkg::TMR_SLOTS);
   localparam logic [2:0] SLOT   = 3'(IDX);

   logic [15:0] ctrl_ff, ctrl_in, ctrl_wr;
   logic [63:0] cmp_ff, cmp_in;
   logic [63:0] per_ff, per_in;
   logic [63:0] cnt_m, cmp_m, sum, rd_ctrl, ctrl_mrg, cmp_mrg, per_mrg;
   logic        per_cap, periodic, m32, hit, ctrl_sel, cmp_sel, pulse, set_status;

   assign per_cap  = (cfg.per_mask & (etb_pkg::PMASK_W'(1) << IDX)) != '0;
   assign periodic = ctrl_ff[etb_pkg::CTRL_PERIODIC] & per_cap;
   assign m32      = ctrl_ff[etb_pkg::CTRL_MODE32] | ~cfg.wide_cap;
   assign hit      = IN_WIN & op.base[8] & (op.base[7:5] == SLOT) & ~op.base[4];
   assign ctrl_sel = hit & ~op.base[3];
   assign cmp_sel  = hit & op.base[3];

   assign cnt_m    = m32 ? {32'd0, count_next[31:0]} : count_next;
   assign cmp_m    = m32 ? {32'd0, cmp_ff[31:0]} : cmp_ff;
   assign sum      = cmp_ff + per_ff;
   assign ctrl_mrg = ({48'd0, ctrl_ff} & ~op.lane) | (op.data & op.lane);
   assign cmp_mrg  = (cmp_ff & ~op.lane) | (op.data & op.lane);
   assign per_mrg  = (per_ff & ~op.lane) | (op.data & op.lane);

   always_comb begin
      rd_ctrl = {48'd0, ctrl_ff & etb_pkg::CTRL_READABLE};
      if (per_cap) rd_ctrl[etb_pkg::CTRL_PER_CAP] = 1'b1;
      else         rd_ctrl[etb_pkg::CTRL_PERIODIC] = 1'b0;
      if (cfg.wide_cap) rd_ctrl[etb_pkg::CTRL_WIDE_CAP] = 1'b1;
   end

   always_comb begin
      ctrl_in    = ctrl_ff;
      cmp_in     = cmp_ff;
      per_in     = per_ff;
      pulse      = 1'b0;
      set_status = 1'b0;
      ctrl_wr    = ctrl_mrg[15:0] & etb_pkg::CTRL_WRITABLE;
      if (!per_cap) ctrl_wr[etb_pkg::CTRL_PERIODIC] = 1'b0;

      if (op.tick && cnt_m == cmp_m) begin
         // advance a periodic comparator past this match
         if (periodic) cmp_in = m32 ? {32'd0, sum[31:0]} : sum;
         if (ctrl_ff[etb_pkg::CTRL_ENABLE]) begin
            if (ctrl_ff[etb_pkg::CTRL_LEVEL]) set_status = 1'b1;
            else                              pulse      = 1'b1;
         end
      end

      if (op.write && ctrl_sel) ctrl_in = ctrl_wr;

      if (op.write && cmp_sel) begin
         if (!periodic || ctrl_ff[etb_pkg::CTRL_SETVAL])
            cmp_in = m32 ? {32'd0, cmp_mrg[31:0]} : cmp_mrg;
         if (periodic)
            per_in = m32 ? {32'd0, per_mrg[31:0]} : per_mrg;
         ctrl_in[etb_pkg::CTRL_SETVAL] = 1'b0;
      end
   end

   always_comb begin
      tout.hit        = hit;
      tout.level_en   = ctrl_in[etb_pkg::CTRL_LEVEL] & ctrl_in[etb_pkg::CTRL_ENABLE];
      tout.pulse      = pulse;
      tout.set_status = set_status;
      tout.rdata      = ctrl_sel ? rd_ctrl : (cmp_sel ? cmp_m : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         cmp_ff  <= '1;
         per_ff  <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
         cmp_ff  <= cmp_in;
         per_ff  <= per_in;
      end
   end

endmodule

>>> rtl/event_timer_block_unit.sv
// Event timer with a main counter and TIMER_COUNT comparators, driven by a
// stream of words: a counter tick, a register read or a register write. One
// word is taken every clock cycle unless the result side stalls; its result
// word passes the input register and then the result register; the longest path
// is the 64-bit counter increment feeding the comparator match and the
// periodic reload select. The capability settings sit behind the APB-style
// port, which is always ready and may be written only while no words are in
// flight.
`include "event_timer_block_unit_defines.svh"

module event_timer_block_unit #(
   parameter int TIMER_COUNT = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [8:0] reg_offset, [9] wide_access, [73:10] write_value, [79:74] zero
   input  logic [79:0]           req_tdata,
   // [1:0] func
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] read_value, then timer_irq, zero padded to whole bytes
   output logic [((64+TIMER_COUNT+7)/8)*8-1:0] rsp_tdata,
   // [0] bad_offset
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int RSP_W = ((64 + TIMER_COUNT + 7) / 8) * 8;

   etb_pkg::cfg_type     cfg;
   etb_pkg::op_type      op;
   etb_pkg::tmr_out_type tmr_out [TIMER_COUNT];

   logic                    s1_valid_ff;
   logic [1:0]              s1_func_ff;
   logic [8:0]              s1_offset_ff;
   logic                    s1_wide_ff;
   logic [63:0]             s1_data_ff;

   logic                    rsp_valid_ff;
   logic [63:0]             rsp_read_ff, rsp_read_in;
   logic [TIMER_COUNT-1:0]  rsp_irq_ff, rsp_irq_in;
   logic                    rsp_bad_ff, rsp_bad_in;

   logic [63:0]             count_ff, count_in, count_next;
   logic                    ge_ff, ge_in;
   logic                    legacy_ff, legacy_in;
   logic [TIMER_COUNT-1:0]  status_ff, status_in;

   logic [TIMER_COUNT-1:0]  pulse_vec, set_vec, level_vec, hit_vec;
   logic                    out_ready, proc, is_acc, is_rd, hi, bad;
   logic [8:0]              base;
   logic [63:0]             lane, data, full, cfg_mrg, count_mrg;

   etb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: the input register drains whenever the result register frees up
   assign out_ready  = ~rsp_valid_ff | rsp_tready;
   assign proc       = s1_valid_ff & out_ready;
   assign req_tready = ~s1_valid_ff | out_ready;

   // access decode
   assign base   = {s1_offset_ff[8:3], 3'b000};
   assign hi     = ~s1_wide_ff & s1_offset_ff[2];
   assign lane   = s1_wide_ff ? '1 : (hi ? {32'hFFFF_FFFF, 32'd0} : {32'd0, 32'hFFFF_FFFF});
   assign data   = s1_wide_ff ? s1_data_ff :
                   (hi ? {s1_data_ff[31:0], 32'd0} : {32'd0, s1_data_ff[31:0]});
   assign is_rd  = s1_func_ff == etb_pkg::FUNC_READ;
   assign is_acc = is_rd | (s1_func_ff == etb_pkg::FUNC_WRITE);

   always_comb begin
      count_next = count_ff + 64'd1;
      if (!cfg.wide_cap) count_next[63:32] = '0;
   end

   always_comb begin
      op.tick  = proc & (s1_func_ff == etb_pkg::FUNC_TICK) & ge_ff;
      op.write = proc & (s1_func_ff == etb_pkg::FUNC_WRITE);
      op.base  = base;
      op.lane  = lane;
      op.data  = data;
   end

   for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_tmr
      etb_timer #(.IDX(g)) u_tmr (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .count_next (count_next),
         .cfg        (cfg),
         .tout       (tmr_out[g])
      );
      assign pulse_vec[g] = tmr_out[g].pulse;
      assign set_vec[g]   = tmr_out[g].set_status;
      assign level_vec[g] = tmr_out[g].level_en;
      assign hit_vec[g]   = tmr_out[g].hit;
   end

   assign cfg_mrg   = ({62'd0, legacy_ff, ge_ff} & ~lane) | (data & lane);
   assign count_mrg = (count_ff & ~lane) | (data & lane);

   // read mux and unmapped detection
   always_comb begin
      full = '0;
      bad  = 1'b0;
      case (base)
         etb_pkg::OFS_CAPS:
            full = {5'd0, cfg.tick_period, etb_pkg::CAPS_VENDOR, cfg.legacy_cap, 1'b0,
                    cfg.wide_cap, 5'(TIMER_COUNT - 1), etb_pkg::CAPS_REV};
         etb_pkg::OFS_CONFIG: full = {62'd0, legacy_ff, ge_ff};
         etb_pkg::OFS_STATUS: full = 64'(status_ff);
         etb_pkg::OFS_COUNT:  full = count_ff;
         default: begin
            for (int n = 0; n < TIMER_COUNT; n++) full = full | tmr_out[n].rdata;
            bad = is_acc & ~(|hit_vec);
         end
      endcase
   end

   // global state update
   always_comb begin
      ge_in     = ge_ff;
      legacy_in = legacy_ff;
      status_in = status_ff;
      count_in  = count_ff;
      if (op.tick) begin
         count_in  = count_next;
         status_in = status_ff | set_vec;
      end
      if (op.write) begin
         case (base)
            etb_pkg::OFS_CONFIG: begin
               ge_in     = cfg_mrg[0];
               legacy_in = cfg_mrg[1];
            end
            etb_pkg::OFS_STATUS: status_in = status_ff & ~data[TIMER_COUNT-1:0];
            etb_pkg::OFS_COUNT:  count_in  = count_mrg;
            default: ;
         endcase
      end
      // hold capability-limited state inside its limits
      legacy_in = legacy_in & cfg.legacy_cap;
      if (!cfg.wide_cap) count_in[63:32] = '0;
   end

   always_comb begin
      rsp_bad_in  = bad;
      rsp_read_in = '0;
      if (is_rd && !bad)
         rsp_read_in = s1_wide_ff ? full : (hi ? {32'd0, full[63:32]} : {32'd0, full[31:0]});
      rsp_irq_in = (ge_in ? (status_in & level_vec) : '0) | pulse_vec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         ge_ff        <= 1'b0;
         legacy_ff    <= 1'b0;
         status_ff    <= '0;
      end else begin
         if (req_tready) s1_valid_ff <= req_tvalid;
         if (proc)            rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         count_ff  <= count_in;
         ge_ff     <= ge_in;
         legacy_ff <= legacy_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_func_ff   <= req_tuser;
         s1_offset_ff <= req_tdata[8:0];
         s1_wide_ff   <= req_tdata[9];
         s1_data_ff   <= req_tdata[73:10];
      end
      if (proc) begin
         rsp_read_ff <= rsp_read_in;
         rsp_irq_ff  <= rsp_irq_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_irq_ff, rsp_read_ff});
   assign rsp_tuser  = rsp_bad_ff;

   `ETB_ASSERT_NOW(a_bad_reads_zero, (rsp_valid_ff && rsp_bad_ff), (rsp_read_ff == '0), "unmapped access returned data")
   `ETB_ASSERT_NEXT(a_narrow_count, (!cfg.wide_cap), (count_ff[63:32] == '0), "narrow counter kept upper dword")
   `ETB_ASSERT_NEXT(a_status_rise, (!op.tick), ((status_ff & ~$past(status_ff)) == '0), "status set without a tick")

endmodule

>>> verif/tb_top.sv
module tb_top;
   import etb_pkg::*;

   localparam int TIMER_NUM = 3;
   localparam logic [1:0] FUNC_NOP = 2'd3;
   localparam logic [8:0] TMR_BASE = 9'h100;
   localparam int TMR_STRIDE = 32;
   localparam logic [8:0] TMR_CMP = 9'h008;
   localparam logic [8:0] TMR_ROUTE = 9'h010;
   localparam logic [8:0] OFS_HI_DWORD = 9'h004;
   localparam logic [63:0] CFG_ENABLE = 64'h1;
   localparam logic [63:0] CFG_LEGACY = 64'h2;
   localparam int RSP_LATENCY = 2;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  func;
      logic [8:0]  ofs;
      logic        wide;
      logic [63:0] wdata;
   } etb_word_t;

   typedef struct packed {
      logic [63:0] rd;
      logic [2:0]  irq;
      logic        bad;
   } etb_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   event_timer_block_unit #(.TIMER_COUNT(TIMER_NUM)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // shadow of the timer block
   logic [TICK_PERIOD_W-1:0] m_period_fs;
   logic                     m_wide_cap;
   logic                     m_legacy_cap;
   logic [PMASK_W-1:0]       m_per_mask;
   logic [63:0]              m_count;
   logic                     m_enable;
   logic                     m_legacy;
   logic [2:0]               m_status;
   logic [15:0]              m_ctrl [TIMER_NUM];
   logic [63:0]              m_cmp [TIMER_NUM];
   logic [63:0]              m_per [TIMER_NUM];

   etb_word_t   word_q [$];
   etb_result_t awaited_rsp_q [$];
   etb_word_t   cur_word;

   int mismatch_count = 0;
   int words_queued = 0;
   int words_sent = 0;
   int results_checked = 0;
   int settings_applied = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int send_wait = 0;
   int recv_wait = 0;
   int long_left = 0;
   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;

   function automatic bit per_capable(int n);
      return m_per_mask[n];
   endfunction

   function automatic bit timer_periodic(int n);
      return m_ctrl[n][CTRL_PERIODIC] && per_capable(n);
   endfunction

   function automatic bit timer_mode32(int n);
      return m_ctrl[n][CTRL_MODE32] || !m_wide_cap;
   endfunction

   function automatic logic [8:0] tmr_ofs(int n, bit is_cmp);
      return TMR_BASE + 9'(n * TMR_STRIDE) + (is_cmp ? TMR_CMP : 9'h000);
   endfunction

   // advance the shadow by one word and return the result it produces
   function automatic etb_result_t predict_timer_rsp(etb_word_t w);
      etb_result_t res;
      logic [8:0]  base;
      logic        hi, wr, m32, per;
      logic [63:0] lane, data, full, merged;
      logic [2:0]  pulses;
      int          n;
      base = {w.ofs[8:3], 3'b000};
      hi = !w.wide && w.ofs[2];
      lane = w.wide ? '1 : (hi ? {32'hFFFF_FFFF, 32'h0} : {32'h0, 32'hFFFF_FFFF});
      data = w.wide ? w.wdata : (hi ? {w.wdata[31:0], 32'h0} : {32'h0, w.wdata[31:0]});
      wr = (w.func == FUNC_WRITE);
      pulses = '0;
      full = '0;
      res = '0;
      if (w.func == FUNC_TICK) begin
         if (m_enable) begin
            m_count = m_count + 64'd1;
            if (!m_wide_cap) m_count[63:32] = '0;
            for (n = 0; n < TIMER_NUM; n++) begin
               m32 = timer_mode32(n);
               if (m32 ? (m_count[31:0] == m_cmp[n][31:0]) : (m_count == m_cmp[n])) begin
                  if (timer_periodic(n)) begin
                     m_cmp[n] = m_cmp[n] + m_per[n];
                     if (m32) m_cmp[n][63:32] = '0;
                  end
                  if (m_ctrl[n][CTRL_ENABLE]) begin
                     if (m_ctrl[n][CTRL_LEVEL]) m_status[n] = 1'b1;
                     else pulses[n] = 1'b1;
                  end
               end
            end
         end
      end else if (w.func == FUNC_READ || wr) begin
         if (base == OFS_CAPS) begin
            full = {5'd0, m_period_fs, CAPS_VENDOR, m_legacy_cap, 1'b0, m_wide_cap,
                    5'(TIMER_NUM - 1), CAPS_REV};
         end else if (base == OFS_CONFIG) begin
            full = {62'd0, m_legacy, m_enable};
            if (wr) begin
               merged = (full & ~lane) | (data & lane);
               m_enable = merged[0];
               m_legacy = m_legacy_cap & merged[1];
            end
         end else if (base == OFS_STATUS) begin
            full = {61'd0, m_status};
            if (wr) m_status = m_status & ~(data[2:0] & lane[2:0]);
         end else if (base == OFS_COUNT) begin
            full = m_count;
            if (wr) begin
               m_count = (m_count & ~lane) | (data & lane);
               if (!m_wide_cap) m_count[63:32] = '0;
            end
         end else if (base[8] && base[7:5] < TIMER_NUM && !base[4]) begin
            n = base[7:5];
            m32 = timer_mode32(n);
            if (!base[3]) begin
               full = {48'd0, m_ctrl[n] & CTRL_READABLE};
               if (per_capable(n)) full[CTRL_PER_CAP] = 1'b1;
               else full[CTRL_PERIODIC] = 1'b0;
               if (m_wide_cap) full[CTRL_WIDE_CAP] = 1'b1;
               if (wr) begin
                  merged = ({48'd0, m_ctrl[n]} & ~lane) | (data & lane);
                  m_ctrl[n] = merged[15:0] & CTRL_WRITABLE;
                  if (!per_capable(n)) m_ctrl[n][CTRL_PERIODIC] = 1'b0;
               end
            end else begin
               full = m32 ? {32'd0, m_cmp[n][31:0]} : m_cmp[n];
               if (wr) begin
                  per = timer_periodic(n);
                  if (!per || m_ctrl[n][CTRL_SETVAL]) begin
                     m_cmp[n] = (m_cmp[n] & ~lane) | (data & lane);
                     if (m32) m_cmp[n][63:32] = '0;
                  end
                  if (per) begin
                     m_per[n] = (m_per[n] & ~lane) | (data & lane);
                     if (m32) m_per[n][63:32] = '0;
                  end
                  m_ctrl[n][CTRL_SETVAL] = 1'b0;
               end
            end
         end else begin
            res.bad = 1'b1;
         end
         if (!wr && !res.bad)
            res.rd = w.wide ? full : (hi ? {32'd0, full[63:32]} : {32'd0, full[31:0]});
      end
      for (n = 0; n < TIMER_NUM; n++)
         if (m_enable && m_ctrl[n][CTRL_LEVEL] && m_ctrl[n][CTRL_ENABLE])
            res.irq[n] = m_status[n];
      res.irq = res.irq | pulses;
      return res;
   endfunction

   // driver: predict each accepted word, then offer the next after its gap
   always @(posedge clock) begin : req_driver
      etb_word_t next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_rsp_q.push_back(predict_timer_rsp(cur_word));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (word_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               next_word = word_q.pop_front();
               cur_word = next_word;
               req_tdata <= {6'd0, next_word.wdata, next_word.wide, next_word.ofs};
               req_tuser <= next_word.func;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
               send_wait = send_steady ? 0 : $urandom_range(0, 13);
            end
         end
      end
   end

   // monitor: check each result word against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      etb_result_t want;
      logic        ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (awaited_rsp_q.size() == 0) begin
               $error("result word with no prediction pending");
               mismatch_count++;
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_tdata[63:0] !== want.rd) begin
                  $error("read_value: expected %h, got %h", want.rd, rsp_tdata[63:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[66:64] !== want.irq) begin
                  $error("timer_irq: expected %b, got %b", want.irq, rsp_tdata[66:64]);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== want.bad) begin
                  $error("bad_offset: expected %b, got %b", want.bad, rsp_tuser[0]);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
            recv_wait = recv_steady ? 0 : $urandom_range(0, 13);
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            long_left = LONG_HOLD;
         end
         if (long_left > 0) begin
            long_left--;
            ready_next = 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   task automatic queue_word(logic [1:0] func, logic [8:0] ofs, logic wide, logic [63:0] wdata);
      etb_word_t w;
      w.func = func;
      w.ofs = ofs;
      w.wide = wide;
      w.wdata = wdata;
      word_q.push_back(w);
      words_queued++;
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_TICK_PERIOD: m_period_fs = val[TICK_PERIOD_W-1:0];
         CSR_WIDE_CAP:    m_wide_cap = val[0];
         CSR_LEGACY_CAP:  m_legacy_cap = val[0];
         CSR_PER_MASK:    m_per_mask = val[PMASK_W-1:0];
         default: ;
      endcase
      if (!m_legacy_cap) m_legacy = 1'b0;
      if (!m_wide_cap) m_count[63:32] = '0;
   endtask

   task automatic apply_settings(int unsigned period, bit wide, bit legacy, int unsigned mask);
      csr_write(CSR_TICK_PERIOD, period);
      csr_write(CSR_WIDE_CAP, wide);
      csr_write(CSR_LEGACY_CAP, legacy);
      csr_write(CSR_PER_MASK, mask);
      settings_applied++;
   endtask

   // hold until every queued word is out and every result is back
   task automatic wait_drained();
      int waited;
      waited = 0;
      while ((word_q.size() != 0 || req_tvalid || awaited_rsp_q.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= DRAIN_LIMIT) begin
         $error("%0d predicted results never arrived", awaited_rsp_q.size());
         mismatch_count++;
         awaited_rsp_q.delete();
      end
      repeat (RSP_LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [8:0] pick_mapped_ofs();
      int k;
      logic [8:0] base;
      k = $urandom_range(0, 3 + 2 * TIMER_NUM);
      case (k)
         0: base = OFS_CAPS;
         1: base = OFS_CONFIG;
         2: base = OFS_STATUS;
         3: base = OFS_COUNT;
         default: base = tmr_ofs((k - 4) / 2, (k % 2) == 1);
      endcase
      return base | 9'($urandom_range(0, 7));
   endfunction

   task automatic queue_random_word();
      int          pick;
      logic [8:0]  ofs;
      logic [63:0] data;
      pick = $urandom_range(0, 99);
      ofs = pick_mapped_ofs();
      data = {$urandom, $urandom};
      if (pick < 35) begin
         queue_word(FUNC_TICK, 9'($urandom_range(0, 511)), 1'($urandom), data);
      end else if (pick < 60) begin
         queue_word(FUNC_READ, ofs, 1'($urandom), data);
      end else if (pick < 90) begin
         if ({ofs[8:3], 3'b000} == OFS_CONFIG) data[0] = ($urandom_range(0, 3) != 0);
         queue_word(FUNC_WRITE, ofs, 1'($urandom), data);
      end else begin
         queue_word(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), 1'($urandom), data);
      end
   endtask

   // program one timer just ahead of the counter, enable, and let it fire
   task automatic queue_timer_scenario();
      int          n, ticks, k;
      logic [63:0] start_count, target, ctrl;
      logic [8:0]  cmp_ofs;
      n = $urandom_range(0, TIMER_NUM - 1);
      cmp_ofs = tmr_ofs(n, 1'b1);
      case ($urandom_range(0, 3))
         0: start_count = {$urandom, $urandom};
         1: start_count = {$urandom, 32'hFFFF_FFF0};
         2: start_count = 64'hFFFF_FFFF_FFFF_FFF0;
         default: start_count = 64'($urandom_range(0, 64));
      endcase
      queue_word(FUNC_WRITE, OFS_COUNT, 1'b1, start_count);
      ctrl = {$urandom, $urandom};
      ctrl[CTRL_ENABLE] = ($urandom_range(0, 9) != 0);
      ctrl[CTRL_PERIODIC] = $urandom_range(0, 1);
      queue_word(FUNC_WRITE, tmr_ofs(n, 1'b0), 1'($urandom), ctrl);
      target = start_count + 64'($urandom_range(1, 6));
      if ($urandom_range(0, 1)) begin
         queue_word(FUNC_WRITE, cmp_ofs, 1'b1, target);
      end else begin
         queue_word(FUNC_WRITE, cmp_ofs, 1'b0, {$urandom, target[31:0]});
         queue_word(FUNC_WRITE, cmp_ofs | OFS_HI_DWORD, 1'b0, {$urandom, target[63:32]});
      end
      if ($urandom_range(0, 1))
         queue_word(FUNC_WRITE, cmp_ofs, 1'b1, 64'($urandom_range(0, 5)));
      queue_word(FUNC_WRITE, OFS_CONFIG, 1'b0, {$urandom, $urandom} | CFG_ENABLE);
      ticks = $urandom_range(3, 24);
      for (k = 0; k < ticks; k++) begin
         if ($urandom_range(0, 99) < 85) queue_word(FUNC_TICK, '0, 1'b0, '0);
         else queue_word(FUNC_READ, pick_mapped_ofs(), 1'($urandom), '0);
      end
      queue_word(FUNC_READ, OFS_STATUS, 1'($urandom), '0);
      queue_word(FUNC_WRITE, OFS_STATUS, 1'($urandom), {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) queue_word(FUNC_WRITE, OFS_CONFIG, 1'b1, '0);
   endtask

   initial begin : limit_guard
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int phase_no, half, target, n;
      m_period_fs = TICK_PERIOD_RST;
      m_wide_cap = 1'b1;
      m_legacy_cap = 1'b1;
      m_per_mask = PMASK_RST;
      m_count = '0;
      m_enable = 1'b0;
      m_legacy = 1'b0;
      m_status = '0;
      for (n = 0; n < TIMER_NUM; n++) begin
         m_ctrl[n] = '0;
         m_cmp[n] = '1;
         m_per[n] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: decode corners, wrap, level, edge and periodic timers
      queue_word(FUNC_READ, OFS_CAPS, 1'b1, '0);
      queue_word(FUNC_READ, OFS_CAPS | OFS_HI_DWORD, 1'b0, '1);
      queue_word(FUNC_WRITE, OFS_CAPS, 1'b1, '1);
      queue_word(FUNC_READ, 9'h008, 1'b1, '0);
      queue_word(FUNC_WRITE, 9'h1FF, 1'b0, '1);
      queue_word(FUNC_READ, tmr_ofs(0, 1'b0) | TMR_ROUTE, 1'b1, '0);
      queue_word(FUNC_READ, tmr_ofs(TIMER_NUM, 1'b0), 1'b0, '0);
      queue_word(FUNC_NOP, '1, 1'b1, '1);
      queue_word(FUNC_TICK, '0, 1'b0, '0);
      queue_word(FUNC_WRITE, OFS_COUNT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_word(FUNC_WRITE, tmr_ofs(1, 1'b0), 1'b1,
                 64'((1 << CTRL_LEVEL) | (1 << CTRL_ENABLE)));
      queue_word(FUNC_WRITE, tmr_ofs(1, 1'b1), 1'b1, '0);
      queue_word(FUNC_WRITE, OFS_CONFIG, 1'b0, CFG_ENABLE | CFG_LEGACY);
      queue_word(FUNC_TICK, '0, 1'b0, '0);
      queue_word(FUNC_TICK, '0, 1'b0, '0);
      queue_word(FUNC_READ, OFS_STATUS, 1'b1, '0);
      queue_word(FUNC_WRITE, OFS_STATUS | OFS_HI_DWORD, 1'b0, '1);
      queue_word(FUNC_WRITE, OFS_STATUS, 1'b0, 64'h7);
      queue_word(FUNC_WRITE, tmr_ofs(0, 1'b0), 1'b1,
                 64'((1 << CTRL_ENABLE) | (1 << CTRL_PERIODIC) | (1 << CTRL_SETVAL)));
      queue_word(FUNC_WRITE, tmr_ofs(0, 1'b1), 1'b1, 64'd2);
      queue_word(FUNC_WRITE, tmr_ofs(0, 1'b1), 1'b1, '0);
      queue_word(FUNC_TICK, '0, 1'b0, '0);
      queue_word(FUNC_TICK, '0, 1'b0, '0);
      queue_word(FUNC_WRITE, tmr_ofs(1, 1'b0), 1'b0,
                 64'((1 << CTRL_PERIODIC) | (1 << CTRL_MODE32) | (1 << CTRL_ENABLE)));
      queue_word(FUNC_READ, tmr_ofs(1, 1'b0), 1'b1, '0);
      wait_drained();

      for (phase_no = 1; phase_no <= 6; phase_no++) begin
         case (phase_no)
            1: apply_settings(1, 1'b0, 1'b0, 0);
            2: apply_settings(100_000_000, 1'b1, 1'b1, 7);
            default: apply_settings($urandom_range(1, 100_000_000), 1'($urandom),
                                    1'($urandom), $urandom_range(0, 7));
         endcase
         for (half = 0; half < 2; half++) begin
            target = words_queued + 135;
            while (words_queued < target) begin
               if ($urandom_range(0, 9) < 7) queue_timer_scenario();
               else repeat (10) queue_random_word();
            end
            // stall the result side while the sender keeps going
            if (phase_no == 2 && half == 0) hold_requests++;
            wait_drained();
         end
      end

      wait_drained();
      $display("Checked %0d results from %0d request words under %0d capability settings.",
               results_checked, words_sent, settings_applied + 1);
      $display("Covered narrow and wide counters, level, edge and periodic timers, bad offsets.");
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/etb_pkg.sv
rtl/etb_csr.sv
rtl/etb_timer.sv
rtl/event_timer_block_unit.sv
verif/tb_top.sv
